// File: src/crystal_ball_density_evaluator_unit_macros.svh
// Assertion macros for the Crystal Ball density evaluator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CRYSTAL_BALL_DENSITY_EVALUATOR_UNIT_MACROS_SVH
`define CRYSTAL_BALL_DENSITY_EVALUATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBDE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cbde_pkg.sv
// Package for the Crystal Ball density evaluator: constants, pipeline stage
// types and the elaboration-time root table builder. No dependencies.
package cbde_pkg;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

  localparam logic [2:0] CFG_CENTER    = 3'd0;
  localparam logic [2:0] CFG_WIDTH     = 3'd1;
  localparam logic [2:0] CFG_ALPHA     = 3'd2;
  localparam logic [2:0] CFG_HIGH_SIDE = 3'd3;
  localparam logic [2:0] CFG_EXPONENT  = 3'd4;

  // Stage through the t = |x - c| / s divider.
  typedef struct packed {
    logic        vld;
    logic [30:0] rem;
    logic [48:0] num;
    logic [48:0] quo;
    logic        neg;
    logic        last;
  } d1_t;

  // Stage after t is known: squared core argument and tail product.
  typedef struct packed {
    logic        vld;
    logic [41:0] tc2;
    logic [54:0] wa;
    logic        tail;
    logic        last;
  } t_t;

  // Stage through the (w * |alpha|) / n divider.
  typedef struct packed {
    logic        vld;
    logic [23:0] rem;
    logic [54:0] num;
    logic [54:0] quo;
    logic [23:0] vcore;
    logic        tail;
    logic        last;
  } d2_t;

  // Leading-one normalization stage.
  typedef struct packed {
    logic        vld;
    logic [55:0] m;
    logic [5:0]  cnt;
    logic [23:0] vcore;
    logic        tail;
    logic        last;
  } nm_t;

  // Logarithm fraction stage, one squaring each.
  typedef struct packed {
    logic        vld;
    logic [31:0] m;
    logic [15:0] fr;
    logic [5:0]  ip;
    logic [23:0] vcore;
    logic        tail;
    logic        last;
  } sq_t;

  // Power-of-two stage, one conditional root multiply each.
  typedef struct packed {
    logic        vld;
    logic [31:0] res;
    logic [15:0] fr;
    logic [4:0]  sh;
    logic        zero;
    logic        tail;
    logic        last;
  } pw_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] density;
    logic        tail;
    logic        last;
  } out_t;

  // Integer square root, used only on constants at elaboration.
  function automatic logic [63:0] cbde_isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = 64'd0;
    b = 64'd1 << 62;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.31 value of 2^(-2^-k), built by repeated square roots of 0.5.
  function automatic logic [31:0] cbde_root_k(input int k);
    logic [63:0] r;
    r = 64'd1 << 30;
    for (int j = 1; j <= k; j++) begin
      r = cbde_isqrt(r << 31);
    end
    return r[31:0];
  endfunction

endpackage

// File: src/cbde_in_if.sv
// Input item channel of the density evaluator: valid/ready and the sample.
// Depends on nothing.
interface cbde_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// File: src/cbde_out_if.sv
// Result item channel of the density evaluator: valid/ready and the result.
// Depends on nothing.
interface cbde_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] density;
  logic        in_tail;
  logic        last_result;

  modport source (output valid, output density, output in_tail, output last_result,
                  input ready);
  modport sink (input valid, input density, input in_tail, input last_result,
                output ready);
endinterface

// File: src/crystal_ball_density_evaluator_unit.sv
// Crystal Ball density evaluator, fully pipelined, one item per cycle.
// Its depth comes mostly from the 49-stage and 55-stage restoring dividers,
// 16 log squarings and 16 root steps.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads register defaults.
`include "crystal_ball_density_evaluator_unit_macros.svh"

module crystal_ball_density_evaluator_unit
  import cbde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  cbde_in_if.sink     in_ch,
  cbde_out_if.source  out_ch
);

  logic signed [31:0] center_r;
  logic [30:0]        width_r;
  logic [23:0]        alpha_r;
  logic               high_r;
  logic [23:0]        expo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= 32'sd0;
      width_r  <= 31'd65536;
      alpha_r  <= 24'd65536;
      high_r   <= 1'b0;
      expo_r   <= 24'd131072;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER:    center_r <= cfg_data;
        CFG_WIDTH:     width_r  <= cfg_data[30:0];
        CFG_ALPHA:     alpha_r  <= cfg_data[23:0];
        CFG_HIGH_SIDE: high_r   <= cfg_data[0];
        CFG_EXPONENT:  expo_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [30:0] s_eff;
  logic [23:0] a_eff;
  logic [23:0] n_eff;
  assign s_eff = (width_r == 31'd0) ? 31'd1 : width_r;
  assign a_eff = (alpha_r == 24'd0) ? 24'd1 : alpha_r;
  assign n_eff = (expo_r == 24'd0) ? 24'd1 : expo_r;

  // The alpha^2/2 term depends only on configuration.
  logic [47:0] aa_r;
  logic [31:0] va_r;
  logic [61:0] ha_prod;
  assign ha_prod = aa_r[47:17] * LOG2E_Q30;
  always_ff @(posedge clk) begin
    aa_r <= a_eff * a_eff;
    va_r <= ha_prod[61:30];
  end

  logic   adv;
  out_t   out_r;
  assign adv = !out_r.vld || out_ch.ready;
  assign in_ch.ready = adv;

  // Input stage: |x - c| and its sign.
  d1_t          s0_r;
  d1_t          s0_nxt;
  logic [32:0]  diff;
  logic [32:0]  mag;
  always_comb begin
    diff = {in_ch.sample[31], in_ch.sample} - {center_r[31], center_r};
    mag  = diff[32] ? (33'd0 - diff) : diff;
    s0_nxt.vld  = in_ch.valid;
    s0_nxt.rem  = 31'd0;
    s0_nxt.num  = {mag, 16'd0};
    s0_nxt.quo  = 49'd0;
    s0_nxt.neg  = diff[32];
    s0_nxt.last = in_ch.last_sample;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.vld <= 1'b0;
    else if (adv) s0_r <= s0_nxt;
  end

  d1_t d1_r [49];
  for (genvar i = 0; i < 49; i++) begin : g_div1
    d1_t         src;
    d1_t         d1_nxt;
    logic [31:0] rsh;
    logic [31:0] rdf;
    logic        ge;
    assign src = (i == 0) ? s0_r : d1_r[(i == 0) ? 0 : i - 1];
    always_comb begin
      rsh = {src.rem, src.num[48]};
      rdf = rsh - {1'b0, s_eff};
      ge  = rsh >= {1'b0, s_eff};
      d1_nxt     = src;
      d1_nxt.rem = ge ? rdf[30:0] : rsh[30:0];
      d1_nxt.num = {src.num[47:0], 1'b0};
      d1_nxt.quo = {src.quo[47:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d1_r[i].vld <= 1'b0;
      else if (adv) d1_r[i] <= d1_nxt;
    end
  end

  // Saturate t, decide the branch, square the core argument, form w*|alpha|.
  t_t          t_r;
  t_t          t_nxt;
  logic [31:0] tm;
  logic [20:0] tc;
  logic [31:0] wdf;
  logic        tail_c;
  always_comb begin
    tm     = (d1_r[48].quo > 49'h0_8000_0000) ? ONE_Q31 : d1_r[48].quo[31:0];
    tail_c = (d1_r[48].neg ^ high_r) && (tm > {8'd0, a_eff});
    tc     = (tm > 32'h0010_0000) ? 21'h10_0000 : tm[20:0];
    wdf    = tail_c ? (tm - {8'd0, a_eff}) : 32'd0;
    t_nxt.vld  = d1_r[48].vld;
    t_nxt.tc2  = tc * tc;
    t_nxt.wa   = wdf[30:0] * a_eff;
    t_nxt.tail = tail_c;
    t_nxt.last = d1_r[48].last;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) t_r.vld <= 1'b0;
    else if (adv) t_r <= t_nxt;
  end

  // Core exponent t^2/2 * log2(e), entering the second divider.
  d2_t         m2_r;
  d2_t         m2_nxt;
  logic [55:0] vc_prod;
  always_comb begin
    vc_prod = t_r.tc2[41:17] * LOG2E_Q30;
    m2_nxt.vld   = t_r.vld;
    m2_nxt.rem   = 24'd0;
    m2_nxt.num   = t_r.wa;
    m2_nxt.quo   = 55'd0;
    m2_nxt.vcore = vc_prod[53:30];
    m2_nxt.tail  = t_r.tail;
    m2_nxt.last  = t_r.last;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) m2_r.vld <= 1'b0;
    else if (adv) m2_r <= m2_nxt;
  end

  d2_t d2_r [55];
  for (genvar i = 0; i < 55; i++) begin : g_div2
    d2_t         src;
    d2_t         d2_nxt;
    logic [24:0] rsh;
    logic [24:0] rdf;
    logic        ge;
    assign src = (i == 0) ? m2_r : d2_r[(i == 0) ? 0 : i - 1];
    always_comb begin
      rsh = {src.rem, src.num[54]};
      rdf = rsh - {1'b0, n_eff};
      ge  = rsh >= {1'b0, n_eff};
      d2_nxt     = src;
      d2_nxt.rem = ge ? rdf[23:0] : rsh[23:0];
      d2_nxt.num = {src.num[53:0], 1'b0};
      d2_nxt.quo = {src.quo[53:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d2_r[i].vld <= 1'b0;
      else if (adv) d2_r[i] <= d2_nxt;
    end
  end

  // q = 1.0 + quotient, then move its leading one to the top bit.
  nm_t nm_src;
  always_comb begin
    nm_src.vld   = d2_r[54].vld;
    nm_src.m     = 56'd65536 + {1'b0, d2_r[54].quo};
    nm_src.cnt   = 6'd0;
    nm_src.vcore = d2_r[54].vcore;
    nm_src.tail  = d2_r[54].tail;
    nm_src.last  = d2_r[54].last;
  end

  nm_t nm_r [6];
  for (genvar i = 0; i < 6; i++) begin : g_norm
    localparam int SH = 32 >> i;
    nm_t src;
    nm_t nm_nxt;
    assign src = (i == 0) ? nm_src : nm_r[(i == 0) ? 0 : i - 1];
    always_comb begin
      nm_nxt = src;
      if (src.m[55 -: SH] == '0) begin
        nm_nxt.m   = src.m << SH;
        nm_nxt.cnt = src.cnt + 6'(SH);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) nm_r[i].vld <= 1'b0;
      else if (adv) nm_r[i] <= nm_nxt;
    end
  end

  // Fraction bits of log2 by repeated squaring of the Q1.31 mantissa.
  sq_t sq_src;
  always_comb begin
    sq_src.vld   = nm_r[5].vld;
    sq_src.m     = nm_r[5].m[55:24];
    sq_src.fr    = 16'd0;
    sq_src.ip    = 6'd39 - nm_r[5].cnt;
    sq_src.vcore = nm_r[5].vcore;
    sq_src.tail  = nm_r[5].tail;
    sq_src.last  = nm_r[5].last;
  end

  sq_t sq_r [16];
  for (genvar i = 0; i < 16; i++) begin : g_sqr
    sq_t         src;
    sq_t         sq_nxt;
    logic [63:0] prod;
    assign src = (i == 0) ? sq_src : sq_r[(i == 0) ? 0 : i - 1];
    always_comb begin
      prod   = src.m * src.m;
      sq_nxt = src;
      if (prod[63]) begin
        sq_nxt.m        = prod[63:32];
        sq_nxt.fr[15-i] = 1'b1;
      end else begin
        sq_nxt.m = prod[62:31];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_r[i].vld <= 1'b0;
      else if (adv) sq_r[i] <= sq_nxt;
    end
  end

  // Total exponent v for the chosen branch, split into shift and fraction.
  pw_t         lg_r;
  pw_t         lg_nxt;
  logic [45:0] nl_prod;
  logic [32:0] vsel;
  always_comb begin
    nl_prod = n_eff * {sq_r[15].ip, sq_r[15].fr};
    vsel    = sq_r[15].tail ? ({1'b0, va_r} + {3'd0, nl_prod[45:16]})
                            : {9'd0, sq_r[15].vcore};
    lg_nxt.vld  = sq_r[15].vld;
    lg_nxt.res  = ONE_Q31;
    lg_nxt.fr   = vsel[15:0];
    lg_nxt.sh   = vsel[20:16];
    lg_nxt.zero = |vsel[32:21];
    lg_nxt.tail = sq_r[15].tail;
    lg_nxt.last = sq_r[15].last;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) lg_r.vld <= 1'b0;
    else if (adv) lg_r <= lg_nxt;
  end

  pw_t pw_r [16];
  for (genvar i = 0; i < 16; i++) begin : g_pow
    localparam logic [31:0] RK = cbde_root_k(i + 1);
    pw_t         src;
    pw_t         pw_nxt;
    logic [63:0] prod;
    assign src = (i == 0) ? lg_r : pw_r[(i == 0) ? 0 : i - 1];
    always_comb begin
      prod   = src.res * RK;
      pw_nxt = src;
      if (src.fr[15-i]) pw_nxt.res = prod[62:31];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) pw_r[i].vld <= 1'b0;
      else if (adv) pw_r[i] <= pw_nxt;
    end
  end

  out_t out_nxt;
  always_comb begin
    out_nxt.vld     = pw_r[15].vld;
    out_nxt.density = pw_r[15].zero ? 32'd0 : (pw_r[15].res >> pw_r[15].sh);
    out_nxt.tail    = pw_r[15].tail;
    out_nxt.last    = pw_r[15].last;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_r.vld <= 1'b0;
    else if (adv) out_r <= out_nxt;
  end

  assign out_ch.valid       = out_r.vld;
  assign out_ch.density     = out_r.density;
  assign out_ch.in_tail     = out_r.tail;
  assign out_ch.last_result = out_r.last;

  `CBDE_ASSERT_SAME(a_density_range, out_r.vld, out_r.density <= ONE_Q31, "density above 1.0")
  `CBDE_ASSERT_SAME(a_norm_lead, nm_r[5].vld, nm_r[5].m[55], "log mantissa not normalized")
  `CBDE_ASSERT_NEXT(a_stall_freeze, !adv, $stable(sq_r[0]), "pipeline moved during stall")

endmodule
